FILE: hdl/ueb_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the unique-entry bounded FIFO.
// Used by the storage cell and by the top level; depends on nothing else.
package ueb_pkg;

   // Default sizes handed to the top-level parameters.
   localparam int DEPTH_DEFAULT    = 16;
   localparam int TAG_BITS_DEFAULT = 32;

   // Fixed widths of the port fields.
   localparam int ITEM_TAG_BITS = 32;
   localparam int CAP_BITS      = 5;
   localparam int COUNT_BITS    = 5;

   localparam logic [CAP_BITS-1:0] CAPACITY_RESET = 5'd16;

   // Operation codes carried by the func field.
   localparam logic FUNC_PUT  = 1'b0;
   localparam logic FUNC_PICK = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_DUP   = 2'd2,
      STATUS_EMPTY = 2'd3
   } status_type;

   // Command broadcast to every cell of the chain.
   typedef struct packed {
      logic load;   // append the put tag at the first free cell
      logic shift;  // every cell takes its tail-side neighbor's contents
   } cell_cmd_type;

endpackage

FILE: hdl/unique_entry_bounded_fifo.sv
`timescale 1ns / 1ps
// Top level of the unique-entry bounded FIFO: a chain of ueb_cell storage cells,
// the entry counter, the capacity register and the registered response stage.
//
// This block is a first-in first-out queue of tags that refuses duplicates.
// A put beat (func = 0) appends item_tag at the tail unless the count has
// reached the capacity register (status full) or an equal tag is already held
// (status duplicate); full wins when both apply. A pick beat (func = 1) removes
// and returns the head tag, or reports empty. Every response beat carries the
// count after the operation, and picked_tag is zero except on a successful pick.
// Each request produces exactly one response beat. A request is decided in the
// cycle it is accepted: every cell compares its tag with the request in
// parallel over the DEPTH cells, ORed into the duplicate flag, so one request
// is accepted per clock cycle while req_stall is low, and its response appears
// in the cycle after. The response sits in a register; req_stall rises only while
// that register is full and the consumer stalls it. Capacity values above DEPTH
// act as DEPTH, and lowering the capacity below the count keeps the held
// entries pickable. Capacity is written over the csr channel, which is always
// ready, and should be changed only while no request is outstanding.
module unique_entry_bounded_fifo import ueb_pkg::*; #(
   parameter int DEPTH    = DEPTH_DEFAULT,
   parameter int TAG_BITS = TAG_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   // Request channel.
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_func,
   input  logic [ITEM_TAG_BITS-1:0] req_item_tag,
   // Response channel.
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_status,
   output logic [ITEM_TAG_BITS-1:0] rsp_picked_tag,
   output logic [COUNT_BITS-1:0]    rsp_entry_count,
   // Capacity register write channel.
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CAP_BITS-1:0]      csr_data
);

   // The counter must hold DEPTH itself; the compare width covers both operands.
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > CAP_BITS) ? CNT_W : CAP_BITS;

   logic                     accept;
   logic [TAG_BITS-1:0]      put_tag;
   logic [DEPTH-1:0]         cell_valid;
   logic [TAG_BITS-1:0]      cell_tag [DEPTH];
   logic [DEPTH-1:0]         cell_match;
   cell_cmd_type             cmd;
   logic                     is_full;
   logic                     is_dup;
   logic                     is_empty;

   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CAP_BITS-1:0]      capacity_ff, capacity_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic [ITEM_TAG_BITS-1:0] rsp_picked_ff, rsp_picked_in;
   logic [COUNT_BITS-1:0]    rsp_count_ff, rsp_count_in;

   // A new request is taken whenever the response register is empty or drains.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // Tags are stored at TAG_BITS; bits above it are dropped, missing bits are zero.
   assign put_tag = TAG_BITS'(req_item_tag);

   // The cell chain. Cell 0 is the head; its head-side neighbor counts as full.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                prev_valid;
      logic                next_valid;
      logic [TAG_BITS-1:0] next_tag;

      if (i == 0) begin : g_head
         assign prev_valid = 1'b1;
      end else begin : g_body
         assign prev_valid = cell_valid[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign next_valid = 1'b0;
         assign next_tag   = '0;
      end else begin : g_link
         assign next_valid = cell_valid[i+1];
         assign next_tag   = cell_tag[i+1];
      end

      ueb_cell #(
         .TAG_BITS(TAG_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .put_tag   (put_tag),
         .prev_valid(prev_valid),
         .next_valid(next_valid),
         .next_tag  (next_tag),
         .valid     (cell_valid[i]),
         .tag       (cell_tag[i]),
         .match     (cell_match[i])
      );
   end

   // Full when the count reaches the capacity or the physical depth.
   assign is_full  = (CMP_W'(count_ff) >= CMP_W'(capacity_ff))
                     || (count_ff == CNT_W'(DEPTH));
   assign is_dup   = |cell_match;
   assign is_empty = (count_ff == '0);

   // Decide the request and drive the cell commands and the next count.
   always_comb begin
      cmd           = '{load: 1'b0, shift: 1'b0};
      count_in      = count_ff;
      rsp_status_in = STATUS_OK;
      rsp_picked_in = '0;
      unique case (req_func)
         FUNC_PUT: begin
            priority if (is_full) begin
               rsp_status_in = STATUS_FULL;
            end else if (is_dup) begin
               rsp_status_in = STATUS_DUP;
            end else begin
               cmd.load = accept;
               count_in = count_ff + 1'b1;
            end
         end
         FUNC_PICK: begin
            if (is_empty) begin
               rsp_status_in = STATUS_EMPTY;
            end else begin
               cmd.shift     = accept;
               count_in      = count_ff - 1'b1;
               rsp_picked_in = ITEM_TAG_BITS'(cell_tag[0]);
            end
         end
         default: begin
            rsp_status_in = STATUS_OK;
         end
      endcase
      rsp_count_in = COUNT_BITS'(count_in);
      rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);
      capacity_in  = (csr_valid && csr_ready) ? csr_data : capacity_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         capacity_ff  <= CAPACITY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         capacity_ff  <= capacity_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload is loaded only with a new beat and holds while stalled.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= rsp_status_in;
         rsp_picked_ff <= rsp_picked_in;
         rsp_count_ff  <= rsp_count_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_picked_tag  = rsp_picked_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

FILE: hdl/ueb_cell.sv
`timescale 1ns / 1ps
// One storage cell of the FIFO chain: a valid bit, a tag and an equality compare.
// Depends on ueb_pkg for the command struct.
module ueb_cell import ueb_pkg::*; #(
   parameter int TAG_BITS = TAG_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  cell_cmd_type        cmd,
   input  logic [TAG_BITS-1:0] put_tag,
   input  logic                prev_valid,
   input  logic                next_valid,
   input  logic [TAG_BITS-1:0] next_tag,
   output logic                valid,
   output logic [TAG_BITS-1:0] tag,
   output logic                match
);

   logic                valid_ff, valid_in;
   logic [TAG_BITS-1:0] tag_ff, tag_in;

   // The first free cell is the empty one whose head-side neighbor is full.
   always_comb begin
      valid_in = valid_ff;
      tag_in   = tag_ff;
      priority if (cmd.shift) begin
         valid_in = next_valid;
         tag_in   = next_tag;
      end else if (cmd.load && !valid_ff && prev_valid) begin
         valid_in = 1'b1;
         tag_in   = put_tag;
      end else begin
         valid_in = valid_ff;
         tag_in   = tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff <= tag_in;
   end

   assign valid = valid_ff;
   assign tag   = tag_ff;
   assign match = valid_ff && (tag_ff == put_tag);

endmodule
